@@ rtl/q4k_block_dequantizer_top_defines.svh @@
// Assertion macros used by the dequantizer controller.
// Define NO_ASSERTIONS to compile every check out of the design.
`ifndef Q4K_BLOCK_DEQUANTIZER_TOP_DEFINES_SVH
`define Q4K_BLOCK_DEQUANTIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define Q4K_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define Q4K_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define Q4K_ASSERT_NOW(label, ante, cons, msg)
`define Q4K_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/q4k_pkg.sv @@
// Types, constants and helper functions for the Q4_K block dequantizer.
// Used by the controller, the datapath and the top level.
package q4k_pkg;

   localparam int unsigned VALUES_PER_BLOCK = 256;
   localparam int unsigned HDR_BYTES        = 16;
   localparam int unsigned BLOCK_BYTES      = HDR_BYTES + VALUES_PER_BLOCK / 2;
   localparam logic [31:0] CANON_NAN        = 32'h7FC0_0000;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_ADD,
      ST_NORM,
      ST_ROUND,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic mul_a;
      logic mul_b;
      logic add;
      logic norm;
      logic round;
      logic odd;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_header;
      logic norm_done;
   } status_type;

   // An fp16 operand as an integer mantissa and a power of two.
   typedef struct packed {
      logic              sign;
      logic [10:0]       mant;
      logic signed [5:0] expo;
      logic              inf;
      logic              nan;
   } half_type;

   // Splits an fp16 pattern so that value = mant * 2^expo.
   function automatic half_type decode_half(input logic [15:0] h);
      half_type   r;
      logic [5:0] ex;
      ex     = {1'b0, h[14:10]} - 6'd25;
      r.sign = h[15];
      r.inf  = 1'b0;
      r.nan  = 1'b0;
      if (h[14:10] == 5'h1F) begin
         r.mant = 11'd0;
         r.expo = 6'sd0;
         r.inf  = (h[9:0] == 10'd0);
         r.nan  = (h[9:0] != 10'd0);
      end else if (h[14:10] != 5'd0) begin
         r.mant = {1'b1, h[9:0]};
         r.expo = signed'(ex);
      end else begin
         r.mant = {1'b0, h[9:0]};
         r.expo = -6'sd24;
      end
      return r;
   endfunction

endpackage

@@ rtl/q4k_ctrl.sv @@
// Controller state machine of the Q4_K block dequantizer.
// Depends on q4k_pkg and the assertion macros header.
`include "q4k_block_dequantizer_top_defines.svh"

module q4k_ctrl
   import q4k_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      odd_ff, odd_in;
   logic      out_valid_ff, out_valid_in;

   // State, lane select and output slot registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         odd_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         odd_ff       <= odd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      odd_in     = odd_ff;
      cmd        = '0;
      cmd.odd    = odd_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && !status.is_header) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            cmd.norm = !status.norm_done;
            if (status.norm_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (!odd_ff) begin
               odd_in   = 1'b1;
               state_in = ST_MUL_A;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               odd_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            odd_in   = 1'b0;
         end
      endcase
   end

   // The output slot fills on a load and empties when the transaction completes.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   `Q4K_ASSERT_NEXT(a_header_stays_idle, req_tvalid && req_tready && status.is_header,
      state_ff == ST_IDLE, "header byte started a computation")
   `Q4K_ASSERT_NOW(a_load_into_free_slot, cmd.load_out,
      !out_valid_ff || rsp_tready, "result overwrote a pending transaction")
   `Q4K_ASSERT_NOW(a_idle_even_lane, state_ff == ST_IDLE, !odd_ff,
      "odd lane selected while idle")
   `Q4K_ASSERT_NOW(a_valid_from_out, $rose(out_valid_ff), $past(state_ff == ST_OUT),
      "result became valid outside the output state")

endmodule

@@ rtl/q4k_datapath.sv @@
// Datapath of the Q4_K block dequantizer: stream position, header capture,
// scale lookup, exact products, alignment, normalization and rounding to fp32.
// Depends on q4k_pkg.
module q4k_datapath
   import q4k_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic [15:0] csr_wdata_ff,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   // Stream position state.
   logic [7:0]  pos_ff;
   logic [15:0] blk_ff;

   // Header storage.
   logic [15:0] dhalf_ff, mhalf_ff;
   logic [7:0]  sc_arr_ff [8];
   logic [7:0]  mn_arr_ff [4];

   // Current data byte and its scale and min.
   logic [7:0] byte_ff;
   logic [5:0] sc_ff;
   logic [1:0] mn_ff;
   logic       bdone_ff, rdone_ff;

   // Arithmetic stage registers.
   logic [9:0]        t1_ff;
   logic [13:0]       magb_ff;
   logic [20:0]       maga_ff;
   logic              sa_ff;
   logic [50:0]       sum_ff;
   logic              sign_ff;
   logic signed [5:0] emin_ff;
   logic              spec_ff;
   logic [31:0]       spec_bits_ff;
   logic [5:0]        sh_ff;
   logic [31:0]       res_even_ff, res_odd_ff;
   logic [31:0]       out_even_ff, out_odd_ff;
   logic              out_bdone_ff, out_rdone_ff;

   // Position of the incoming byte, with a row start taken into account.
   logic [7:0]  pos_eff;
   logic [15:0] blk_eff;
   logic [7:0]  off;
   logic [3:0]  grp;
   logic [7:0]  sc_byte, mn_byte, mn_shift;
   logic [5:0]  sc_val;
   logic        last_pos, last_blk;
   logic [15:0] bpr_eff;
   logic [16:0] blk_inc;

   always_comb begin
      pos_eff  = req_tuser ? 8'd0 : pos_ff;
      blk_eff  = req_tuser ? 16'd0 : blk_ff;
      off      = pos_eff - 8'(HDR_BYTES);
      grp      = off[6:3];
      sc_byte  = sc_arr_ff[grp[3:1]];
      mn_byte  = mn_arr_ff[grp[3:2]];
      sc_val   = grp[0] ? {4'd0, sc_byte[7:6]} : sc_byte[5:0];
      mn_shift = mn_byte >> {grp[1:0], 1'b0};
      last_pos = (pos_eff == 8'(BLOCK_BYTES - 1));
      bpr_eff  = (csr_wdata_ff == 16'd0) ? 16'd1 : csr_wdata_ff;
      blk_inc  = {1'b0, blk_eff} + 17'd1;
      last_blk = (blk_inc >= {1'b0, bpr_eff});
      status.is_header = (pos_eff < 8'(HDR_BYTES));
      status.norm_done = sum_ff[50] || (sum_ff == 51'd0);
   end

   // Byte position and block count.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 8'd0;
         blk_ff <= 16'd0;
      end else if (cmd.accept) begin
         if (status.is_header || !last_pos) begin
            pos_ff <= pos_eff + 8'd1;
            blk_ff <= blk_eff;
         end else begin
            pos_ff <= 8'd0;
            blk_ff <= last_blk ? 16'd0 : blk_inc[15:0];
         end
      end
   end

   // Header capture and data byte latch.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (status.is_header) begin
            case (pos_eff)
               8'd0: dhalf_ff[7:0]  <= req_tdata;
               8'd1: dhalf_ff[15:8] <= req_tdata;
               8'd2: mhalf_ff[7:0]  <= req_tdata;
               8'd3: mhalf_ff[15:8] <= req_tdata;
               default: begin
                  if (pos_eff < 8'd12) begin
                     sc_arr_ff[pos_eff[2:0] - 3'd4] <= req_tdata;
                  end else begin
                     mn_arr_ff[pos_eff[1:0]] <= req_tdata;
                  end
               end
            endcase
         end else begin
            byte_ff  <= req_tdata;
            sc_ff    <= sc_val;
            mn_ff    <= mn_shift[1:0];
            bdone_ff <= last_pos;
            rdone_ff <= last_pos && last_blk;
         end
      end
   end

   // Decoded header halves.
   half_type dh, mh;
   assign dh = decode_half(dhalf_ff);
   assign mh = decode_half(mhalf_ff);

   // First products: |q-8|*sc and dmin mantissa times (mn+1).
   logic [3:0] nib, qmag;
   logic       qneg;
   always_comb begin
      nib  = cmd.odd ? byte_ff[7:4] : byte_ff[3:0];
      qneg = !nib[3];
      qmag = nib[3] ? {1'b0, nib[2:0]} : (4'd8 - nib);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_a) begin
         t1_ff   <= 10'(qmag) * 10'(sc_ff);
         magb_ff <= 14'(mh.mant) * 14'({1'b0, mn_ff} + 3'd1);
         sa_ff   <= dh.sign ^ qneg;
      end
      if (cmd.mul_b) begin
         maga_ff <= 21'(dh.mant) * 21'(t1_ff);
      end
   end

   // Alignment to the smaller exponent, exact signed sum and special values.
   logic [5:0]  diff;
   logic [50:0] ala, alb;
   logic        a_nan, a_inf, r_nan, r_inf, r_inf_sign;
   always_comb begin
      if (dh.expo >= mh.expo) begin
         diff = 6'(dh.expo - mh.expo);
         ala  = {30'd0, maga_ff} << diff[4:0];
         alb  = {37'd0, magb_ff};
      end else begin
         diff = 6'(mh.expo - dh.expo);
         ala  = {30'd0, maga_ff};
         alb  = {37'd0, magb_ff} << diff[4:0];
      end
      a_nan      = dh.nan || (dh.inf && (t1_ff == 10'd0));
      a_inf      = dh.inf && (t1_ff != 10'd0);
      r_nan      = a_nan || mh.nan || (a_inf && mh.inf && (sa_ff != mh.sign));
      r_inf      = a_inf || mh.inf;
      r_inf_sign = a_inf ? sa_ff : mh.sign;
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         emin_ff      <= (dh.expo >= mh.expo) ? mh.expo : dh.expo;
         sh_ff        <= 6'd0;
         spec_ff      <= r_nan || r_inf;
         spec_bits_ff <= r_nan ? CANON_NAN : {r_inf_sign, 8'hFF, 23'd0};
         if (sa_ff == mh.sign) begin
            sum_ff  <= ala + alb;
            sign_ff <= sa_ff;
         end else if (ala >= alb) begin
            sum_ff  <= ala - alb;
            sign_ff <= (ala == alb) ? 1'b0 : sa_ff;
         end else begin
            sum_ff  <= alb - ala;
            sign_ff <= mh.sign;
         end
      end else if (cmd.norm) begin
         // Shift left by a byte while the top byte is clear, else by one bit.
         if (sum_ff[50:43] == 8'd0) begin
            sum_ff <= sum_ff << 8;
            sh_ff  <= sh_ff + 6'd8;
         end else begin
            sum_ff <= sum_ff << 1;
            sh_ff  <= sh_ff + 6'd1;
         end
      end
   end

   // Round to nearest even and pack the fp32 pattern.
   logic [24:0]       rnd;
   logic              inc;
   logic signed [8:0] exp9;
   logic [31:0]       rbits;
   always_comb begin
      inc  = sum_ff[26] && ((|sum_ff[25:0]) || sum_ff[27]);
      rnd  = {1'b0, sum_ff[50:27]} + {24'd0, inc};
      exp9 = 9'(emin_ff) + 9'sd177 - signed'({3'd0, sh_ff}) + signed'({8'd0, rnd[24]});
      if (spec_ff) begin
         rbits = spec_bits_ff;
      end else if (sum_ff == 51'd0) begin
         rbits = {sign_ff, 31'd0};
      end else begin
         rbits = {sign_ff, exp9[7:0], rnd[24] ? 23'd0 : rnd[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         if (cmd.odd) begin
            res_odd_ff <= rbits;
         end else begin
            res_even_ff <= rbits;
         end
      end
      if (cmd.load_out) begin
         out_even_ff  <= res_even_ff;
         out_odd_ff   <= res_odd_ff;
         out_bdone_ff <= bdone_ff;
         out_rdone_ff <= rdone_ff;
      end
   end

   assign rsp_tdata = {out_odd_ff, out_even_ff};
   assign rsp_tuser = out_bdone_ff;
   assign rsp_tlast = out_rdone_ff;

endmodule

@@ rtl/q4k_block_dequantizer_top.sv @@
// Channel   Dir  Payload
// req_*     in   tdata[7:0] data_byte; tuser[0] row_start
// rsp_*     out  tdata[31:0] value_even, [63:32] value_odd; tuser block_done; tlast row_done
// csr_*     in   wdata[15:0] blocks_per_row
// A header byte is taken while the controller is idle and gives no transaction.
// A data byte keeps the input closed while its two values run in turn through
// one shared multiply, align, normalize and round unit, each with two multiply steps, an
// add, normalization shifts of a byte or a bit and a rounding step, then the output loads.
// Reset is synchronous and sets blocks_per_row to one.
// A result waits in an output register, so a stalled response holds only the next.
// Top level of the Q4_K block dequantizer; depends on q4k_pkg, q4k_ctrl
// and q4k_datapath.
module q4k_block_dequantizer_top
   import q4k_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] row_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] value_even, [63:32] value_odd
   output logic        rsp_tuser,   // [0] block_done
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);

   logic [15:0] bpr_ff;
   cmd_type     cmd;
   status_type  status;

   // Blocks-per-row register.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpr_ff <= 16'd1;
      end else if (csr_wen) begin
         bpr_ff <= csr_wdata;
      end
   end

   q4k_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   q4k_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .csr_wdata_ff (bpr_ff),
      .cmd          (cmd),
      .status       (status),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
